@@ sv/shs_pkg.sv @@
// shs_pkg: shared constants, types and round constants for the SHA-1 stream hasher.
// No dependencies; imported by shs_ram users, shs_engine and sha1_stream_hasher.
`timescale 1ns / 1ps

package shs_pkg;

   localparam int WORD_W       = 32;
   localparam int SCHED_DEPTH  = 16;
   localparam int SCHED_AW     = 4;
   localparam int READ_PORTS   = 4;
   localparam int ROUNDS       = 80;
   localparam int DIGEST_WORDS = 5;
   localparam int INDEX_W      = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [0:DIGEST_WORDS-1] chain_type;
   typedef logic [SCHED_AW-1:0] sched_addr_type;
   typedef sched_addr_type [0:READ_PORTS-1] sched_raddr_type;
   typedef word_type [0:READ_PORTS-1] sched_rdata_type;

   localparam chain_type H_INIT = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_R0 = 32'h5A827999;
   localparam word_type K_R1 = 32'h6ED9EBA1;
   localparam word_type K_R2 = 32'h8F1BBCDC;
   localparam word_type K_R3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   typedef struct packed {
      logic start;
      logic reinit;
   } eng_ctl_type;

   typedef struct packed {
      logic busy;
   } eng_stat_type;

   typedef struct packed {
      logic            wr_en;
      sched_addr_type  wr_addr;
      word_type        wr_data;
      sched_raddr_type rd_addr;
   } sched_req_type;

endpackage

@@ sv/shs_ram.sv @@
// shs_ram: generic synchronous RAM, one write port, two read ports, registered read.
// No dependencies.
`timescale 1ns / 1ps

module shs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

@@ sv/shs_engine.sv @@
// shs_engine: SHA-1 compression, one round a cycle, schedule words held in RAM.
// Owns the chaining value and working registers. Depends on shs_pkg.
`timescale 1ns / 1ps

module shs_engine
   import shs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  eng_ctl_type     ctl,
   input  sched_rdata_type rd_data,
   output sched_req_type   sreq,
   output eng_stat_type    stat,
   output chain_type       chain
);

   typedef enum logic [1:0] {E_IDLE, E_RUN, E_FOLD} st_type;

   st_type    st_ff, st_in;
   logic [6:0] rnd_ff, rnd_in;
   chain_type chain_ff, chain_in;
   chain_type wrk_ff, wrk_in;

   logic [6:0] iss;
   word_type   w_mix, w_cur, f_val, k_val, t_val;
   word_type   a, b, c, d, e;

   assign a = wrk_ff[0];
   assign b = wrk_ff[1];
   assign c = wrk_ff[2];
   assign d = wrk_ff[3];
   assign e = wrk_ff[4];

   // reads for the next round are issued during the current round, as the RAM read is registered
   assign iss = (st_ff == E_IDLE) ? 7'd0 : rnd_ff + 7'd1;

   assign sreq.rd_addr[0] = iss[SCHED_AW-1:0] + 4'd13;
   assign sreq.rd_addr[1] = iss[SCHED_AW-1:0] + 4'd8;
   assign sreq.rd_addr[2] = iss[SCHED_AW-1:0] + 4'd2;
   assign sreq.rd_addr[3] = iss[SCHED_AW-1:0];

   assign w_mix = rd_data[0] ^ rd_data[1] ^ rd_data[2] ^ rd_data[3];
   assign w_cur = (rnd_ff < 7'(SCHED_DEPTH)) ? rd_data[3] : {w_mix[30:0], w_mix[31]};

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (b & c) | (~b & d);
         k_val = K_R0;
      end else if (rnd_ff < 7'd40) begin
         f_val = b ^ c ^ d;
         k_val = K_R1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (b & c) | (b & d) | (c & d);
         k_val = K_R2;
      end else begin
         f_val = b ^ c ^ d;
         k_val = K_R3;
      end
   end

   assign t_val = {a[26:0], a[31:27]} + f_val + e + k_val + w_cur;

   assign sreq.wr_en   = (st_ff == E_RUN) && (rnd_ff >= 7'(SCHED_DEPTH));
   assign sreq.wr_addr = rnd_ff[SCHED_AW-1:0];
   assign sreq.wr_data = w_cur;

   assign stat.busy = (st_ff != E_IDLE);
   assign chain     = chain_ff;

   always_comb begin
      st_in    = st_ff;
      rnd_in   = rnd_ff;
      chain_in = chain_ff;
      wrk_in   = wrk_ff;
      case (st_ff)
         E_IDLE: begin
            if (ctl.start) begin
               st_in  = E_RUN;
               rnd_in = 7'd0;
               wrk_in = chain_ff;
            end
            if (ctl.reinit) begin
               chain_in = H_INIT;
            end
         end
         E_RUN: begin
            wrk_in = '{t_val, a, {b[1:0], b[31:2]}, c, d};
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(ROUNDS - 1)) begin
               st_in = E_FOLD;
            end
         end
         E_FOLD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + wrk_ff[i];
            end
            st_in = E_IDLE;
         end
         default: begin
            st_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      wrk_ff <= wrk_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         st_ff    <= E_IDLE;
         chain_ff <= H_INIT;
      end else begin
         st_ff    <= st_in;
         chain_ff <= chain_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> st_ff == E_IDLE)
      else $error("compression started while busy");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      st_ff == E_RUN |-> rnd_ff < 7'(ROUNDS))
      else $error("round counter out of range");
`endif

endmodule

@@ sv/sha1_stream_hasher.sv @@
// sha1_stream_hasher: streaming SHA-1, byte intake, padding sequencer and digest output.
// Depends on shs_pkg, shs_ram and shs_engine.
`timescale 1ns / 1ps
//
//  channel  dir  ports                                              beat
//  req      in   req_valid req_stall req_kind req_data_byte         one byte or finish
//  rsp      out  rsp_valid rsp_stall rsp_digest_word               one digest word
//                rsp_word_index rsp_last
//
//  A data byte is taken in the cycle it is offered; the 64th byte of a block starts a
//  compression (kick, 80 rounds, fold, handback) in the one-round-a-cycle engine reading
//  the schedule RAM. A finish adds the pad bytes (up to 72), one or two compressions, then
//  5 digest beats; req_stall stays high from the finish until the last beat is taken.
//  Reset needs no clearing pass. rsp_stall holds the current word in place.

module sha1_stream_hasher
   import shs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_digest_word,
   output logic [INDEX_W-1:0]   rsp_word_index,
   output logic                 rsp_last
);

   typedef enum logic [2:0] {S_IDLE, S_PAD, S_KICK, S_WAIT, S_OUT} st_type;

   st_type             st_ff, st_in;
   logic [63:0]        count_ff, count_in;
   logic [7:0][7:0]    len_ff, len_in;
   logic [23:0]        asm_ff, asm_in;
   logic               fin_ff, fin_in;
   logic               lenph_ff, lenph_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;

   logic [5:0]         pos;
   logic               push_en, push_wr, in_len;
   logic [7:0]         push_byte;

   eng_ctl_type        eng_ctl;
   eng_stat_type       eng_stat;
   sched_req_type      sreq;
   sched_rdata_type    rd_data;
   chain_type          chain;

   logic               ram_wr_en;
   sched_addr_type     ram_wr_addr;
   word_type           ram_wr_data;

   assign pos     = count_ff[8:3];
   assign in_len  = lenph_ff || (pos == LEN_POS);
   assign push_wr = push_en && (pos[1:0] == 2'd3);

   always_comb begin
      st_in     = st_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      asm_in    = asm_ff;
      fin_in    = fin_ff;
      lenph_in  = lenph_ff;
      idx_in    = idx_ff;
      push_en   = 1'b0;
      push_byte = 8'd0;
      eng_ctl   = '0;
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               push_en = 1'b1;
               if (req_kind) begin
                  push_byte = PAD_MARK;
                  len_in    = count_ff;
                  fin_in    = 1'b1;
                  lenph_in  = 1'b0;
                  st_in     = S_PAD;
               end else begin
                  push_byte = req_data_byte;
               end
            end
         end
         S_PAD: begin
            push_en   = 1'b1;
            push_byte = in_len ? len_ff[~pos[2:0]] : 8'd0;
            lenph_in  = in_len;
         end
         S_KICK: begin
            eng_ctl.start = 1'b1;
            st_in         = S_WAIT;
         end
         S_WAIT: begin
            if (!eng_stat.busy) begin
               if (!fin_ff) begin
                  st_in = S_IDLE;
               end else if (lenph_ff) begin
                  st_in  = S_OUT;
                  idx_in = '0;
               end else begin
                  st_in = S_PAD;
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == INDEX_W'(DIGEST_WORDS - 1)) begin
                  eng_ctl.reinit = 1'b1;
                  count_in       = '0;
                  fin_in         = 1'b0;
                  lenph_in       = 1'b0;
                  st_in          = S_IDLE;
               end
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
      if (push_en) begin
         asm_in   = {asm_ff[15:0], push_byte};
         count_in = count_ff + 64'd8;
         if (pos == LAST_POS) begin
            st_in = S_KICK;
         end
      end
   end

   always_comb begin
      if (eng_stat.busy) begin
         ram_wr_en   = sreq.wr_en;
         ram_wr_addr = sreq.wr_addr;
         ram_wr_data = sreq.wr_data;
      end else begin
         ram_wr_en   = push_wr;
         ram_wr_addr = pos[5:2];
         ram_wr_data = {asm_ff, push_byte};
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
      len_ff <= len_in;
      idx_ff <= idx_in;
      if (reset) begin
         st_ff    <= S_IDLE;
         count_ff <= '0;
         fin_ff   <= 1'b0;
         lenph_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         lenph_ff <= lenph_in;
      end
   end

   assign req_stall       = (st_ff != S_IDLE);
   assign rsp_valid       = (st_ff == S_OUT);
   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last        = (idx_ff == INDEX_W'(DIGEST_WORDS - 1));

   // schedule memory, duplicated for four reads a cycle
   shs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SCHED_DEPTH)
   ) u_sched_lo (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (sreq.rd_addr[0]),
      .rd_addr_b (sreq.rd_addr[1]),
      .rd_data_a (rd_data[0]),
      .rd_data_b (rd_data[1])
   );

   shs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SCHED_DEPTH)
   ) u_sched_hi (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (sreq.rd_addr[2]),
      .rd_addr_b (sreq.rd_addr[3]),
      .rd_data_a (rd_data[2]),
      .rd_data_b (rd_data[3])
   );

   shs_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctl     (eng_ctl),
      .rd_data (rd_data),
      .sreq    (sreq),
      .stat    (eng_stat),
      .chain   (chain)
   );

`ifndef NO_ASSERTIONS
   a_no_load_in_rounds: assert property (@(posedge clock) disable iff (reset)
      push_wr |-> !eng_stat.busy)
      else $error("buffer write while compression runs");

   a_clear_after_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> count_ff == 64'd0 && !fin_ff)
      else $error("state not cleared after last digest beat");
`endif

endmodule
